### rtl/tcbfl_pkg.sv
package tcbfl_pkg;

	localparam int MAX_SLOTS    = 256;
	localparam int POOLS        = 2;
	localparam int SLOT_W       = $clog2(MAX_SLOTS);
	localparam int CNT_W        = SLOT_W + 1;
	localparam int ADDR_W       = SLOT_W + 1;
	localparam int COUNTER_BITS = 32;
	localparam int UTIL_W       = 7;
	localparam int PCT          = 100;
	localparam int PROD_W       = CNT_W + UTIL_W;
	localparam int STEP_W       = $clog2(UTIL_W);

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic CFG_SMALL_COUNT = 1'b0;
	localparam logic CFG_LARGE_COUNT = 1'b1;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_EXHAUSTED   = 2'd1,
		ST_DOUBLE_FREE = 2'd2,
		ST_INVALID     = 2'd3
	} status_t;

	typedef struct packed {
		logic capture;
		logic mem_read;
		logic exec;
		logic div_init;
		logic div_step;
		logic load_out;
	} dp_cmd_t;

	function automatic logic [COUNTER_BITS-1:0] sat_inc(input logic [COUNTER_BITS-1:0] v);
		return (&v) ? v : v + COUNTER_BITS'(1);
	endfunction

endpackage

### rtl/tcbfl_ctrl.sv
module tcbfl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  logic               clr_busy,
	output tcbfl_pkg::dp_cmd_t cmd
);
	import tcbfl_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_READ  = 6'b000010,
		S_EXEC  = 6'b000100,
		S_DINIT = 6'b001000,
		S_DIV   = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && !clr_busy) begin
					cmd.capture = 1'b1;
					state_d     = S_READ;
				end
			end
			S_READ: begin
				cmd.mem_read = 1'b1;
				state_d      = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_DINIT;
			end
			S_DINIT: begin
				cmd.div_init = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == STEP_W'(UTIL_W - 1))
					state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_init)
				step_q <= '0;
			else if (cmd.div_step)
				step_q <= step_q + STEP_W'(1);
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != S_IDLE) || clr_busy;
	assign out_valid = out_valid_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("result not presented after load");

endmodule

### rtl/tcbfl_datapath.sv
module tcbfl_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  tcbfl_pkg::dp_cmd_t                    cmd,
	output logic                                  clr_busy,
	input  logic                                  op,
	input  logic                                  pool_sel,
	input  logic [tcbfl_pkg::SLOT_W-1:0]          slot_in,
	input  logic                                  cfg_we,
	input  logic                                  cfg_index,
	input  logic [tcbfl_pkg::CNT_W-1:0]           cfg_data,
	output logic [1:0]                            status,
	output logic [tcbfl_pkg::SLOT_W-1:0]          slot_out,
	output logic [tcbfl_pkg::CNT_W-1:0]           free_slots,
	output logic [tcbfl_pkg::CNT_W-1:0]           used_slots,
	output logic [tcbfl_pkg::CNT_W-1:0]           peak_used,
	output logic [tcbfl_pkg::COUNTER_BITS-1:0]    alloc_total,
	output logic [tcbfl_pkg::COUNTER_BITS-1:0]    free_total,
	output logic [tcbfl_pkg::COUNTER_BITS-1:0]    fail_total,
	output logic [tcbfl_pkg::UTIL_W-1:0]          util_percent
);
	import tcbfl_pkg::*;

	logic              op_q, pool_q;
	logic [SLOT_W-1:0] slot_q;

	logic [CNT_W-1:0]        count_q [POOLS];
	logic [CNT_W-1:0]        depth_q [POOLS];
	logic [CNT_W-1:0]        peak_q  [POOLS];
	logic [CNT_W-1:0]        mark_q  [POOLS];
	logic [COUNTER_BITS-1:0] alloc_q [POOLS];
	logic [COUNTER_BITS-1:0] free_q  [POOLS];
	logic [COUNTER_BITS-1:0] fail_q  [POOLS];

	// flag clearing pass after a rebuild, small pool first
	logic [POOLS-1:0]  clr_pend_q;
	logic [SLOT_W-1:0] clr_idx_q [POOLS];
	logic              clr_sel;

	logic [SLOT_W-1:0] stack_mem [POOLS*MAX_SLOTS];
	logic              flag_mem  [POOLS*MAX_SLOTS];
	logic [SLOT_W-1:0] stack_rd_q;
	logic              flag_rd_q;

	status_t           res_status_q;
	logic [SLOT_W-1:0] res_slot_q;

	logic [CNT_W-1:0]  rem_q;
	logic [UTIL_W-1:0] num_q, quot_q;
	logic              div_zero_q;

	status_t           out_status_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [CNT_W-1:0]  out_free_q, out_used_q, out_peak_q;
	logic [COUNTER_BITS-1:0] out_alloc_q, out_freec_q, out_fail_q;
	logic [UTIL_W-1:0] out_util_q;

	// exec decode
	logic [CNT_W-1:0]  cur_count, cur_depth, top_idx, used_pop, used_now, cfg_n;
	logic [SLOT_W-1:0] granted;
	logic              slot_ok, slot_free;
	status_t           exec_status;
	logic              stack_we, flag_we, flag_wdata;
	logic [SLOT_W-1:0] flag_idx;
	logic [PROD_W-1:0] prod;
	logic [CNT_W:0]    div_trial;
	logic              div_bit;

	assign clr_busy = |clr_pend_q;
	assign clr_sel  = !clr_pend_q[0];

	always_comb begin
		cur_count = count_q[pool_q];
		cur_depth = depth_q[pool_q];
		top_idx   = cur_depth - CNT_W'(1);
		granted   = (top_idx < mark_q[pool_q]) ? top_idx[SLOT_W-1:0] : stack_rd_q;
		used_pop  = cur_count - top_idx;
		used_now  = cur_count - cur_depth;
		slot_ok   = ({1'b0, slot_q} < cur_count);
		slot_free = flag_rd_q;
		exec_status = ST_OK;
		stack_we    = 1'b0;
		flag_we     = 1'b0;
		flag_wdata  = 1'b0;
		flag_idx    = slot_q;
		if (op_q == OP_ALLOC) begin
			if (cur_depth == '0) begin
				exec_status = ST_EXHAUSTED;
			end else begin
				flag_we  = 1'b1;
				flag_idx = granted;
			end
		end else begin
			if (!slot_ok) begin
				exec_status = ST_INVALID;
			end else if (slot_free) begin
				exec_status = ST_DOUBLE_FREE;
			end else begin
				stack_we   = 1'b1;
				flag_we    = 1'b1;
				flag_wdata = 1'b1;
			end
		end
		cfg_n     = (cfg_data > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : cfg_data;
		prod      = PROD_W'(used_now) * PROD_W'(PCT);
		div_trial = {rem_q, num_q[UTIL_W-1]};
		div_bit   = (div_trial >= {1'b0, cur_count});
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= op;
			pool_q <= pool_sel;
			slot_q <= slot_in;
		end
		if (cmd.mem_read) begin
			stack_rd_q <= stack_mem[{pool_q, top_idx[SLOT_W-1:0]}];
			flag_rd_q  <= flag_mem[{pool_q, slot_q}];
		end
		if (clr_busy)
			flag_mem[{clr_sel, clr_idx_q[clr_sel]}] <= 1'b1;
		else if (cmd.exec && flag_we)
			flag_mem[{pool_q, flag_idx}] <= flag_wdata;
		if (cmd.exec) begin
			if (stack_we)
				stack_mem[{pool_q, cur_depth[SLOT_W-1:0]}] <= slot_q;
			res_status_q <= exec_status;
			res_slot_q   <= (op_q == OP_ALLOC && exec_status == ST_OK) ? granted : '0;
		end
		if (cmd.div_init) begin
			rem_q      <= prod[PROD_W-1:UTIL_W];
			num_q      <= prod[UTIL_W-1:0];
			quot_q     <= '0;
			div_zero_q <= (cur_count == '0);
		end else if (cmd.div_step) begin
			rem_q  <= div_bit ? CNT_W'(div_trial - {1'b0, cur_count}) : div_trial[CNT_W-1:0];
			num_q  <= {num_q[UTIL_W-2:0], 1'b0};
			quot_q <= {quot_q[UTIL_W-2:0], div_bit};
		end
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
			out_free_q   <= cur_depth;
			out_used_q   <= used_now;
			out_peak_q   <= peak_q[pool_q];
			out_alloc_q  <= alloc_q[pool_q];
			out_freec_q  <= free_q[pool_q];
			out_fail_q   <= fail_q[pool_q];
			out_util_q   <= div_zero_q ? '0 : quot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < POOLS; p++) begin
				clr_pend_q[p] <= 1'b0;
				clr_idx_q[p]  <= '0;
			end
		end else begin
			for (int p = 0; p < POOLS; p++) begin
				if (cfg_we && cfg_index == 1'(p)) begin
					clr_pend_q[p] <= 1'b1;
					clr_idx_q[p]  <= '0;
				end else if (clr_busy && clr_sel == 1'(p)) begin
					clr_idx_q[p] <= clr_idx_q[p] + SLOT_W'(1);
					if (&clr_idx_q[p])
						clr_pend_q[p] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < POOLS; p++) begin
				count_q[p]   <= '0;
				depth_q[p]   <= '0;
				peak_q[p]    <= '0;
				mark_q[p]    <= '0;
				alloc_q[p]   <= '0;
				free_q[p]    <= '0;
				fail_q[p]    <= '0;
			end
		end else if (cfg_we) begin
			count_q[cfg_index]   <= cfg_n;
			depth_q[cfg_index]   <= cfg_n;
			mark_q[cfg_index]    <= cfg_n;
			peak_q[cfg_index]    <= '0;
			alloc_q[cfg_index]   <= '0;
			free_q[cfg_index]    <= '0;
			fail_q[cfg_index]    <= '0;
		end else if (cmd.exec) begin
			if (op_q == OP_ALLOC) begin
				if (cur_depth == '0) begin
					fail_q[pool_q] <= sat_inc(fail_q[pool_q]);
				end else begin
					depth_q[pool_q] <= top_idx;
					alloc_q[pool_q] <= sat_inc(alloc_q[pool_q]);
					if (used_pop > peak_q[pool_q])
						peak_q[pool_q] <= used_pop;
				end
			end else if (stack_we) begin
				depth_q[pool_q] <= cur_depth + CNT_W'(1);
				free_q[pool_q]  <= sat_inc(free_q[pool_q]);
				if (cur_depth < mark_q[pool_q])
					mark_q[pool_q] <= cur_depth;
			end
		end
	end

	assign status       = out_status_q;
	assign slot_out     = out_slot_q;
	assign free_slots   = out_free_q;
	assign used_slots   = out_used_q;
	assign peak_used    = out_peak_q;
	assign alloc_total  = out_alloc_q;
	assign free_total   = out_freec_q;
	assign fail_total   = out_fail_q;
	assign util_percent = out_util_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		depth_q[0] <= count_q[0] && depth_q[1] <= count_q[1])
		else $error("free depth above pool count");

	assert property (@(posedge clk) disable iff (!arst_n)
		peak_q[0] <= count_q[0] && peak_q[1] <= count_q[1])
		else $error("peak above pool count");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> !clr_busy)
		else $error("request taken during flag clearing");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out && !div_zero_q |-> quot_q <= UTIL_W'(PCT))
		else $error("utilization above one hundred");

endmodule

### rtl/two_class_buffer_free_list.sv
// Two-class buffer slot pool: a small pool and a large pool, each with a
// LIFO free stack of slot indices and a free flag per slot.
// Request channel (in_valid/in_stall): op allocates (pops) or frees (pushes)
// a slot of the pool named by pool_sel. Result channel (out_valid/out_stall):
// status, granted slot, occupancy, peak, saturating counters, utilization.
// Config port: cfg_we writes cfg_data to small_count (index 0) or
// large_count (index 1). Count, depth and counters of that pool change at
// once; a pass then marks each of the pool's 256 slot flags free, with in_stall
// high meanwhile (small pool first when both pools are rebuilt back to back).
// Write only while no request is in flight.
// A request moves through the states READ (stack and flag memory read),
// EXEC (update), DINIT, DIV and OUT; one request is handled at a time and
// the next is taken once the controller is back in IDLE and no flag pass runs.
// DIV is the restoring divider for used*100/count, one quotient bit per
// cycle for the seven-bit quotient; OUT loads the result register.
// A stalled result stays in the output register; the next request is
// accepted meanwhile and waits for it before its own result is loaded.
// Reset: both counts zero, every pool empty, no slot free, counters zero.
module two_class_buffer_free_list (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               op,
	input  logic                               pool_sel,
	input  logic [tcbfl_pkg::SLOT_W-1:0]       slot_in,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [1:0]                         status,
	output logic [tcbfl_pkg::SLOT_W-1:0]       slot_out,
	output logic [tcbfl_pkg::CNT_W-1:0]        free_slots,
	output logic [tcbfl_pkg::CNT_W-1:0]        used_slots,
	output logic [tcbfl_pkg::CNT_W-1:0]        peak_used,
	output logic [tcbfl_pkg::COUNTER_BITS-1:0] alloc_total,
	output logic [tcbfl_pkg::COUNTER_BITS-1:0] free_total,
	output logic [tcbfl_pkg::COUNTER_BITS-1:0] fail_total,
	output logic [tcbfl_pkg::UTIL_W-1:0]       util_percent,
	input  logic                               cfg_we,
	input  logic                               cfg_index,
	input  logic [tcbfl_pkg::CNT_W-1:0]        cfg_data
);
	import tcbfl_pkg::*;

	dp_cmd_t cmd;
	logic    clr_busy;

	tcbfl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.clr_busy  (clr_busy),
		.cmd       (cmd)
	);

	tcbfl_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.clr_busy     (clr_busy),
		.op           (op),
		.pool_sel     (pool_sel),
		.slot_in      (slot_in),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.status       (status),
		.slot_out     (slot_out),
		.free_slots   (free_slots),
		.used_slots   (used_slots),
		.peak_used    (peak_used),
		.alloc_total  (alloc_total),
		.free_total   (free_total),
		.fail_total   (fail_total),
		.util_percent (util_percent)
	);

endmodule

### dv/tb.sv
module tb;
	import tcbfl_pkg::*;

	localparam logic POOL_SMALL = 1'b0;
	localparam logic POOL_LARGE = 1'b1;
	localparam int   CHK        = 0;	// copy of the pools checked against the DUT
	localparam int   GEN        = 1;	// copy used to steer stimulus
	localparam int   QUIET_MAX  = 2000;
	localparam int   SETTLE     = 20;

	typedef struct packed {
		logic              op;
		logic              pool;
		logic [SLOT_W-1:0] slot;
	} pool_req_t;

	typedef struct packed {
		status_t                 status;
		logic [SLOT_W-1:0]       slot;
		logic [CNT_W-1:0]        free_n;
		logic [CNT_W-1:0]        used_n;
		logic [CNT_W-1:0]        peak_n;
		logic [COUNTER_BITS-1:0] allocs;
		logic [COUNTER_BITS-1:0] frees;
		logic [COUNTER_BITS-1:0] refusals;
		logic [UTIL_W-1:0]       util;
	} pool_report_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic                    op;
	logic                    pool_sel;
	logic [SLOT_W-1:0]       slot_in;
	logic                    out_valid;
	logic                    out_stall;
	logic [1:0]              status;
	logic [SLOT_W-1:0]       slot_out;
	logic [CNT_W-1:0]        free_slots;
	logic [CNT_W-1:0]        used_slots;
	logic [CNT_W-1:0]        peak_used;
	logic [COUNTER_BITS-1:0] alloc_total;
	logic [COUNTER_BITS-1:0] free_total;
	logic [COUNTER_BITS-1:0] fail_total;
	logic [UTIL_W-1:0]       util_percent;
	logic                    cfg_we;
	logic                    cfg_index;
	logic [CNT_W-1:0]        cfg_data;

	two_class_buffer_free_list DUT (.*);

	// pool state, two copies
	int unsigned             pool_size  [2][POOLS];
	logic [SLOT_W-1:0]       stack_mem  [2][POOLS][MAX_SLOTS];
	bit                      is_free    [2][POOLS][MAX_SLOTS];
	int unsigned             stack_ptr  [2][POOLS];
	int unsigned             high_water [2][POOLS];
	logic [COUNTER_BITS-1:0] allocs     [2][POOLS];
	logic [COUNTER_BITS-1:0] frees      [2][POOLS];
	logic [COUNTER_BITS-1:0] refusals   [2][POOLS];

	pool_req_t    req_q[$];
	pool_report_t pool_reports_q[$];
	int           outstanding = 0;
	int           mismatches = 0;
	int           send_idle_pct = 0;
	int           recv_stall_pct = 0;
	int           hold_left = 0;
	int           quiet = 0;
	logic         req_taken = 1'b0;

	function automatic logic [COUNTER_BITS-1:0] bump(logic [COUNTER_BITS-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic void rebuild(int m, logic p, logic [CNT_W-1:0] v);
		int unsigned n;
		n = (v > MAX_SLOTS) ? MAX_SLOTS : v;
		pool_size[m][p] = n;
		for (int i = 0; i < MAX_SLOTS; i++) begin
			is_free[m][p][i] = (i < n);
			if (i < n)
				stack_mem[m][p][i] = SLOT_W'(i);
		end
		stack_ptr[m][p]  = n;
		high_water[m][p] = 0;
		allocs[m][p]     = '0;
		frees[m][p]      = '0;
		refusals[m][p]   = '0;
	endfunction

	function automatic pool_report_t pool_step(int m, logic opf, logic p, logic [SLOT_W-1:0] s);
		pool_report_t r;
		int unsigned  used;
		r = '0;
		r.status = ST_OK;
		if (opf == OP_ALLOC) begin
			if (stack_ptr[m][p] == 0) begin
				r.status = ST_EXHAUSTED;
				refusals[m][p] = bump(refusals[m][p]);
			end else begin
				stack_ptr[m][p]--;
				r.slot = stack_mem[m][p][stack_ptr[m][p]];
				is_free[m][p][r.slot] = 1'b0;
				allocs[m][p] = bump(allocs[m][p]);
				used = pool_size[m][p] - stack_ptr[m][p];
				if (used > high_water[m][p])
					high_water[m][p] = used;
			end
		end else if (s >= pool_size[m][p]) begin
			r.status = ST_INVALID;
		end else if (is_free[m][p][s]) begin
			r.status = ST_DOUBLE_FREE;
		end else begin
			stack_mem[m][p][stack_ptr[m][p]] = s;
			stack_ptr[m][p]++;
			is_free[m][p][s] = 1'b1;
			frees[m][p] = bump(frees[m][p]);
		end
		used = pool_size[m][p] - stack_ptr[m][p];
		r.free_n   = CNT_W'(stack_ptr[m][p]);
		r.used_n   = CNT_W'(used);
		r.peak_n   = CNT_W'(high_water[m][p]);
		r.allocs   = allocs[m][p];
		r.frees    = frees[m][p];
		r.refusals = refusals[m][p];
		r.util     = pool_size[m][p] ? UTIL_W'((used * PCT) / pool_size[m][p]) : '0;
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] pick_count();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return '0;
		if (r < 16)
			return CNT_W'(MAX_SLOTS);
		if (r < 22)
			return CNT_W'($urandom_range(511, MAX_SLOTS + 1));
		return CNT_W'($urandom_range(16, 1));
	endfunction

	task automatic check_field(string name, logic [COUNTER_BITS-1:0] want,
			logic [COUNTER_BITS-1:0] got);
		if (want !== got) begin
			$display("%0t %s: expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic queue_req(logic opf, logic p, logic [SLOT_W-1:0] s);
		pool_req_t r;
		r.op   = opf;
		r.pool = p;
		r.slot = s;
		req_q.push_back(r);
		outstanding++;
		void'(pool_step(GEN, opf, p, s));
	endtask

	task automatic write_count(logic idx, logic [CNT_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		rebuild(CHK, idx, v);
		rebuild(GEN, idx, v);
	endtask

	task automatic wait_idle();
		wait (outstanding == 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic queue_random(int n);
		logic              p;
		logic              opf;
		logic [SLOT_W-1:0] s;
		int                sel;
		int                busy[$];
		for (int k = 0; k < n; k++) begin
			p   = 1'($urandom_range(1));
			sel = $urandom_range(99);
			opf = (sel < 50) ? OP_ALLOC : OP_FREE;
			s   = SLOT_W'($urandom_range(255));
			if (sel >= 50 && sel < 93 && pool_size[GEN][p] > 0) begin
				busy.delete();
				for (int i = 0; i < pool_size[GEN][p]; i++)
					if (!is_free[GEN][p][i])
						busy.push_back(i);
				if (sel < 85 && busy.size() > 0)
					s = SLOT_W'(busy[$urandom_range(busy.size() - 1)]);
				else
					s = SLOT_W'($urandom_range(pool_size[GEN][p] - 1));
			end
			queue_req(opf, p, s);
		end
	endtask

	task automatic run_phase(int n, int send_pct, int recv_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		for (int c = 0; c < n; c += 50) begin
			wait_idle();
			write_count(CFG_SMALL_COUNT, pick_count());
			write_count(CFG_LARGE_COUNT, pick_count());
			queue_random(50);
		end
	endtask

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// request driver
	always @(negedge clk) begin : drive
		pool_req_t r;
		if (arst_n && (!in_valid || req_taken)) begin
			if (req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				r = req_q.pop_front();
				in_valid <= 1'b1;
				op       <= r.op;
				pool_sel <= r.pool;
				slot_in  <= r.slot;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver; long hold-offs counted here
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// predict at request acceptance
	always @(posedge clk) begin
		req_taken <= in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall)
			pool_reports_q.push_back(pool_step(CHK, op, pool_sel, slot_in));
	end

	always @(posedge clk) begin : monitor
		pool_report_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pool_reports_q.size() == 0) begin
				$display("%0t unexpected result: expected none, got status %0d slot %0d",
					$time, status, slot_out);
				mismatches++;
			end else begin
				want = pool_reports_q.pop_front();
				check_field("status", want.status, status);
				check_field("slot_out", want.slot, slot_out);
				check_field("free_slots", want.free_n, free_slots);
				check_field("used_slots", want.used_n, used_slots);
				check_field("peak_used", want.peak_n, peak_used);
				check_field("alloc_total", want.allocs, alloc_total);
				check_field("free_total", want.frees, free_total);
				check_field("fail_total", want.refusals, fail_total);
				check_field("util_percent", want.util, util_percent);
				outstanding--;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_MAX) begin
				$display("FAIL two_class_buffer_free_list");
				$finish;
			end
		end
	end

	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		op        = OP_ALLOC;
		pool_sel  = POOL_SMALL;
		slot_in   = '0;
		out_stall = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_SMALL_COUNT;
		cfg_data  = '0;
		for (int m = 0; m < 2; m++)
			for (int p = 0; p < POOLS; p++) begin
				rebuild(m, p, '0);
				for (int i = 0; i < MAX_SLOTS; i++)
					stack_mem[m][p][i] = '0;
			end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// before any rebuild: every free is out of range, allocs refused
		queue_req(OP_ALLOC, POOL_SMALL, 8'h00);
		queue_req(OP_FREE, POOL_LARGE, 8'h00);
		wait_idle();

		write_count(CFG_SMALL_COUNT, 9'd4);
		write_count(CFG_LARGE_COUNT, 9'd0);
		queue_req(OP_ALLOC, POOL_LARGE, 8'hff);
		queue_req(OP_FREE, POOL_LARGE, 8'h00);
		queue_req(OP_FREE, POOL_SMALL, 8'h00);
		queue_req(OP_FREE, POOL_SMALL, 8'h04);
		queue_req(OP_FREE, POOL_SMALL, 8'hff);
		repeat (5) queue_req(OP_ALLOC, POOL_SMALL, 8'h00);
		queue_req(OP_FREE, POOL_SMALL, 8'h02);
		queue_req(OP_FREE, POOL_SMALL, 8'h02);
		queue_req(OP_FREE, POOL_SMALL, 8'h00);
		queue_req(OP_ALLOC, POOL_SMALL, 8'h00);
		wait_idle();

		// count above the slot limit is clamped
		write_count(CFG_SMALL_COUNT, 9'h1ff);
		write_count(CFG_LARGE_COUNT, 9'd256);
		queue_req(OP_FREE, POOL_LARGE, 8'hff);
		queue_req(OP_ALLOC, POOL_LARGE, 8'h00);
		queue_req(OP_FREE, POOL_LARGE, 8'hff);
		queue_req(OP_ALLOC, POOL_SMALL, 8'h00);
		queue_req(OP_FREE, POOL_SMALL, 8'h80);
		queue_req(OP_ALLOC, POOL_LARGE, 8'h00);
		wait_idle();

		write_count(CFG_SMALL_COUNT, 9'd1);
		write_count(CFG_LARGE_COUNT, 9'd1);
		queue_req(OP_ALLOC, POOL_SMALL, 8'h00);
		queue_req(OP_ALLOC, POOL_SMALL, 8'h00);
		queue_req(OP_FREE, POOL_SMALL, 8'h00);
		queue_req(OP_ALLOC, POOL_LARGE, 8'h00);

		run_phase(150, 0, 0);
		run_phase(150, 85, 0);
		run_phase(150, 0, 85);
		run_phase(150, 23, 23);

		// receiver holds off while requests keep coming
		wait_idle();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		write_count(CFG_SMALL_COUNT, 9'd8);
		write_count(CFG_LARGE_COUNT, 9'd8);
		wait (!in_stall);
		@(posedge clk);
		hold_left = 300;
		queue_random(40);

		wait (outstanding == 0);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && pool_reports_q.size() == 0)
			$display("PASS two_class_buffer_free_list");
		else
			$display("FAIL two_class_buffer_free_list");
		$finish;
	end

endmodule

### two_class_buffer_free_list.f
rtl/tcbfl_pkg.sv
rtl/tcbfl_ctrl.sv
rtl/tcbfl_datapath.sv
rtl/two_class_buffer_free_list.sv
dv/tb.sv
